// ===== rtl/m3i_pkg.sv =====
// shared types, widths and cofactor index tables for the 3x3 matrix inverse
// no dependencies
`timescale 1ns / 1ps
package m3i_pkg;
  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int FIELD_W    = 32;
  localparam int N_ELEM     = 9;
  localparam int LAST_IDX   = N_ELEM - 1;
  localparam int CNT_W      = 4;
  localparam int PROD_W     = 2 * ELEM_WIDTH;
  localparam int COF_W      = (2 * ELEM_WIDTH + 1 > 64) ? 64 : 2 * ELEM_WIDTH + 1;
  localparam int HALF_W     = 32;
  localparam int COF_HI_W   = COF_W - HALF_W;
  localparam int TERM_W     = ELEM_WIDTH + COF_W;
  localparam int DET_W      = TERM_W + 2;
  localparam int NUM_W      = COF_W + 2 * FRAC_BITS;
  localparam int CMP_W      = DET_W + ELEM_WIDTH;

  // cof[k] = a[CA[k]] * a[CB[k]] - a[CC[k]] * a[CD[k]]
  localparam int CA [N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int CB [N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int CC [N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
  localparam int CD [N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [COF_W-1:0]      cof_t;

  typedef struct packed {
    logic [FIELD_W-1:0] in_c0r0;
    logic [FIELD_W-1:0] in_c0r1;
    logic [FIELD_W-1:0] in_c0r2;
    logic [FIELD_W-1:0] in_c1r0;
    logic [FIELD_W-1:0] in_c1r1;
    logic [FIELD_W-1:0] in_c1r2;
    logic [FIELD_W-1:0] in_c2r0;
    logic [FIELD_W-1:0] in_c2r1;
    logic [FIELD_W-1:0] in_c2r2;
  } mat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_c0r0;
    logic [FIELD_W-1:0] out_c0r1;
    logic [FIELD_W-1:0] out_c0r2;
    logic [FIELD_W-1:0] out_c1r0;
    logic [FIELD_W-1:0] out_c1r1;
    logic [FIELD_W-1:0] out_c1r2;
    logic [FIELD_W-1:0] out_c2r0;
    logic [FIELD_W-1:0] out_c2r1;
    logic [FIELD_W-1:0] out_c2r2;
    logic               singular;
    logic               clipped;
  } res_t;

  typedef struct packed {
    cof_t             cof;
    logic [DET_W-1:0] den;
    logic             den_neg;
    elem_t            elem;
    logic             sing;
    logic             last;
  } tok_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               clip;
    logic               sing;
    logic               last;
  } quo_t;
endpackage

// ===== rtl/m3i_front.sv =====
// cofactor and determinant pipeline, seven stalling register stages
// depends on m3i_pkg
`timescale 1ns / 1ps
module m3i_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  m3i_pkg::elem_t      a_in  [m3i_pkg::N_ELEM],
  output logic                out_valid,
  input  logic                out_take,
  output m3i_pkg::elem_t      a_out [m3i_pkg::N_ELEM],
  output m3i_pkg::cof_t       cof_out [m3i_pkg::N_ELEM],
  output logic [m3i_pkg::DET_W-1:0] den_out,
  output logic                neg_out,
  output logic                sing_out
);
  import m3i_pkg::*;

  localparam int NS = 7;

  logic [NS:1] v;
  logic [NS:1] rdy;

  elem_t a1 [N_ELEM];
  elem_t a2 [N_ELEM];
  elem_t a3 [N_ELEM];
  elem_t a4 [N_ELEM];
  elem_t a5 [N_ELEM];
  elem_t a6 [N_ELEM];
  elem_t a7 [N_ELEM];
  logic signed [PROD_W-1:0] pp [N_ELEM];
  logic signed [PROD_W-1:0] pq [N_ELEM];
  cof_t c3 [N_ELEM];
  cof_t c4 [N_ELEM];
  cof_t c5 [N_ELEM];
  cof_t c6 [N_ELEM];
  cof_t c7 [N_ELEM];
  logic signed [TERM_W-1:0] plo [3];
  logic signed [TERM_W-1:0] phi [3];
  logic signed [DET_W-1:0]  t5 [3];
  logic signed [DET_W-1:0]  det6;
  logic [DET_W-1:0]         den7;
  logic                     neg7;
  logic                     sing7;

  assign rdy[NS] = !v[NS] || out_take;
  genvar s, k;
  generate
    for (s = 1; s < NS; s++) begin : g_rdy
      assign rdy[s] = !v[s] || rdy[s+1];
    end
  endgenerate
  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int i = 2; i <= NS; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) a1 <= a_in;
    if (rdy[2]) a2 <= a1;
    if (rdy[3]) a3 <= a2;
    if (rdy[4]) a4 <= a3;
    if (rdy[5]) a5 <= a4;
    if (rdy[6]) a6 <= a5;
    if (rdy[7]) a7 <= a6;
    if (rdy[4]) c4 <= c3;
    if (rdy[5]) c5 <= c4;
    if (rdy[6]) c6 <= c5;
    if (rdy[7]) c7 <= c6;
  end

  generate
    for (k = 0; k < N_ELEM; k++) begin : g_cof
      always_ff @(posedge clk) begin
        if (rdy[2]) begin
          pp[k] <= a1[CA[k]] * a1[CB[k]];
          pq[k] <= a1[CC[k]] * a1[CD[k]];
        end
        if (rdy[3]) c3[k] <= COF_W'(pp[k]) - COF_W'(pq[k]);
      end
    end
    for (k = 0; k < 3; k++) begin : g_det
      always_ff @(posedge clk) begin
        if (rdy[4]) begin
          plo[k] <= a3[k] * $signed({1'b0, c3[3*k][HALF_W-1:0]});
          phi[k] <= a3[k] * $signed(c3[3*k][COF_W-1:HALF_W]);
        end
        if (rdy[5]) t5[k] <= (DET_W'(phi[k]) <<< HALF_W) + DET_W'(plo[k]);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy[6]) det6 <= t5[0] + t5[1] + t5[2];
    if (rdy[7]) begin
      neg7  <= det6[DET_W-1];
      den7  <= det6[DET_W-1] ? DET_W'(-det6) : DET_W'(det6);
      sing7 <= (det6 == '0);
    end
  end

  assign out_valid = v[NS];
  assign a_out     = a7;
  assign cof_out   = c7;
  assign den_out   = den7;
  assign neg_out   = neg7;
  assign sing_out  = sing7;
endmodule

// ===== rtl/m3i_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with saturation
// depends on m3i_pkg
`timescale 1ns / 1ps
module m3i_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  m3i_pkg::tok_t tok,
  output logic          out_valid,
  output m3i_pkg::quo_t quo
);
  import m3i_pkg::*;

  localparam int EW = ELEM_WIDTH;

  logic [EW:0]       v;
  logic [NUM_W-1:0]  rem  [EW+1];
  logic [EW-1:0]     q    [EW+1];
  logic [DET_W-1:0]  den  [EW+1];
  logic [EW:0]       neg;
  logic [EW:0]       ovf;
  logic [EW:0]       sing;
  logic [EW:0]       last;
  elem_t             elem [EW+1];

  logic [COF_W-1:0]  cmag;
  logic [NUM_W-1:0]  num;

  assign cmag = tok.cof[COF_W-1] ? COF_W'(-tok.cof) : COF_W'(tok.cof);
  assign num  = {cmag, {(2*FRAC_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[EW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= num;
    q[0]    <= '0;
    den[0]  <= tok.den;
    neg[0]  <= tok.cof[COF_W-1] ^ tok.den_neg;
    ovf[0]  <= CMP_W'(num) >= {tok.den, {EW{1'b0}}};
    sing[0] <= tok.sing;
    last[0] <= tok.last;
    elem[0] <= tok.elem;
  end

  genvar j;
  generate
    for (j = 1; j <= EW; j++) begin : g_bit
      logic [CMP_W-1:0] sh;
      logic             ge;
      assign sh = CMP_W'(den[j-1]) << (EW - j);
      assign ge = CMP_W'(rem[j-1]) >= sh;
      always_ff @(posedge clk) begin
        rem[j]  <= ge ? rem[j-1] - sh[NUM_W-1:0] : rem[j-1];
        q[j]    <= {q[j-1][EW-2:0], ge};
        den[j]  <= den[j-1];
        neg[j]  <= neg[j-1];
        ovf[j]  <= ovf[j-1];
        sing[j] <= sing[j-1];
        last[j] <= last[j-1];
        elem[j] <= elem[j-1];
      end
    end
  endgenerate

  logic [EW-1:0] qq;
  logic          clip_p;
  logic          clip_n;
  logic [EW-1:0] val;

  assign qq     = q[EW];
  assign clip_p = ovf[EW] || qq[EW-1];
  assign clip_n = ovf[EW] || (qq[EW-1] && (|qq[EW-2:0]));

  always_comb begin
    if (neg[EW]) begin
      val = clip_n ? {1'b1, {(EW-1){1'b0}}} : EW'(-qq);
    end else begin
      val = clip_p ? {1'b0, {(EW-1){1'b1}}} : qq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v[EW];
    end
  end

  always_ff @(posedge clk) begin
    quo.value <= sing[EW] ? FIELD_W'(elem[EW]) : FIELD_W'($signed(val));
    quo.clip  <= sing[EW] ? 1'b0 : (neg[EW] ? clip_n : clip_p);
    quo.sing  <= sing[EW];
    quo.last  <= last[EW];
  end
endmodule

// ===== rtl/matrix3_inverse.sv =====
// Inverse of a column-major 3x3 signed Q16.16 matrix by adjugate over
// determinant. Raise start with a matrix on mat; it is taken when busy is
// low. Each matrix gives one result on res, marked by done for one cycle;
// the receiver must take it then. The nine cofactor quotients share one
// pipelined divider, one quotient a cycle; a seven-stage cofactor and
// determinant pipeline ahead of it buffers up to seven more. With the
// divider idle, a matrix taken on mat passes the 7 front stages, a hold
// register, the issue of its earlier quotients, 34 divider registers and
// the result register before done is raised.
// Singular matrices come back unchanged with res.singular set.
// depends on m3i_pkg, m3i_front, m3i_div
`timescale 1ns / 1ps
module matrix3_inverse (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  m3i_pkg::mat_t mat,
  output logic          done,
  output m3i_pkg::res_t res
);
  import m3i_pkg::*;

  elem_t            a_in [N_ELEM];
  logic             f_ready;
  logic             f_valid;
  logic             take;
  elem_t            f_a [N_ELEM];
  cof_t             f_cof [N_ELEM];
  logic [DET_W-1:0] f_den;
  logic             f_neg;
  logic             f_sing;

  assign a_in[0] = mat.in_c0r0[ELEM_WIDTH-1:0];
  assign a_in[1] = mat.in_c0r1[ELEM_WIDTH-1:0];
  assign a_in[2] = mat.in_c0r2[ELEM_WIDTH-1:0];
  assign a_in[3] = mat.in_c1r0[ELEM_WIDTH-1:0];
  assign a_in[4] = mat.in_c1r1[ELEM_WIDTH-1:0];
  assign a_in[5] = mat.in_c1r2[ELEM_WIDTH-1:0];
  assign a_in[6] = mat.in_c2r0[ELEM_WIDTH-1:0];
  assign a_in[7] = mat.in_c2r1[ELEM_WIDTH-1:0];
  assign a_in[8] = mat.in_c2r2[ELEM_WIDTH-1:0];

  assign busy = !f_ready;

  m3i_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_ready  (f_ready),
    .a_in      (a_in),
    .out_valid (f_valid),
    .out_take  (take),
    .a_out     (f_a),
    .cof_out   (f_cof),
    .den_out   (f_den),
    .neg_out   (f_neg),
    .sing_out  (f_sing)
  );

  // issue sequencer: one cofactor per cycle into the divider
  logic             active;
  logic [CNT_W-1:0] cnt;
  logic             at_last;
  logic             load;
  elem_t            h_a [N_ELEM];
  cof_t             h_cof [N_ELEM];
  logic [DET_W-1:0] h_den;
  logic             h_neg;
  logic             h_sing;

  assign at_last = (cnt == CNT_W'(LAST_IDX));
  assign take    = !active || at_last;
  assign load    = take && f_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (load) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      if (at_last) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      h_a    <= f_a;
      h_cof  <= f_cof;
      h_den  <= f_den;
      h_neg  <= f_neg;
      h_sing <= f_sing;
    end
  end

  tok_t tok;
  assign tok.cof     = h_cof[cnt];
  assign tok.den     = h_den;
  assign tok.den_neg = h_neg;
  assign tok.elem    = h_a[cnt];
  assign tok.sing    = h_sing;
  assign tok.last    = at_last;

  logic q_valid;
  quo_t quo;

  m3i_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (active),
    .tok       (tok),
    .out_valid (q_valid),
    .quo       (quo)
  );

  // gather nine quotients into one result beat
  logic [FIELD_W-1:0] sh [LAST_IDX];
  logic               clip_acc;

  always_ff @(posedge clk) begin
    if (q_valid) begin
      for (int i = 0; i < LAST_IDX - 1; i++) sh[i] <= sh[i+1];
      sh[LAST_IDX-1] <= quo.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      clip_acc <= 1'b0;
    end else begin
      done <= q_valid && quo.last;
      if (q_valid) begin
        clip_acc <= quo.last ? 1'b0 : (clip_acc | quo.clip);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && quo.last) begin
      res.out_c0r0 <= sh[0];
      res.out_c0r1 <= sh[1];
      res.out_c0r2 <= sh[2];
      res.out_c1r0 <= sh[3];
      res.out_c1r1 <= sh[4];
      res.out_c1r2 <= sh[5];
      res.out_c2r0 <= sh[6];
      res.out_c2r1 <= sh[7];
      res.out_c2r2 <= quo.value;
      res.singular <= quo.sing;
      res.clipped  <= clip_acc | quo.clip;
    end
  end

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(q_valid && quo.last))
    else $error("result beat without a closing quotient");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(LAST_IDX))
    else $error("issue counter out of range");

  a_hold_issue: assert property (@(posedge clk) disable iff (rst)
    (active && !at_last) |=> (active && cnt == $past(cnt) + 1'b1))
    else $error("issue sequence broken mid matrix");

  a_sing_clip: assert property (@(posedge clk) disable iff (rst)
    (done && res.singular) |-> !res.clipped)
    else $error("singular result flagged as clipped");
endmodule
